// File: hw/rtl/bdlp_pkg.sv
// Shared types and constants for the button debounce / long press block.
package bdlp_pkg;

  localparam int DEF_NUM_BUTTONS = 2;
  localparam int DEF_TICK_MS     = 10;

  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int COUNT_W         = 13;
  localparam int HELD_W          = 16;

  localparam logic [CFG_W-1:0]   DEF_DEBOUNCE_MS = CFG_W'(30);
  localparam logic [CFG_W-1:0]   DEF_LONG_MS     = CFG_W'(3000);
  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
  localparam logic [HELD_W-1:0]  HELD_MAX        = {HELD_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_MS = 1'b0,
    REG_LONG_MS     = 1'b1
  } cfg_reg_t;

  // Per-button event from one tick.
  typedef struct packed {
    logic hit;
    logic is_long;
  } lane_evt_t;

endpackage

// File: hw/rtl/button_debounce_long_press_top.sv
// Top level of the multi-button debouncer with short and long press events.
//
// Each input transaction is one tick of TICK_MS ms carrying the active-low raw
// levels of all buttons. A tick is taken into an input register; once the
// event register can load, every button lane updates its debounce count,
// debounced state and held time, and the events go into the event register.
// Events leave one per cycle while out_ready is high, in button order, with
// last marking the final event of a tick; a tick that causes no event
// produces no output transaction. A tick without events, or with one event
// taken at once, frees the event register, so ticks stream at one per cycle;
// a tick with k events holds it until its last is taken, which sets the
// throughput. A new tick is accepted while the previous tick's final event
// is being taken. Register writes (index 0: debounce ms, index 1: long press
// ms; zero selects 30 or 3000 ms) apply from the next tick processed. The
// debounce time becomes a tick count on the write, clamped to 8191.
module button_debounce_long_press_top import bdlp_pkg::*; #(
  parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
  parameter int TICK_MS     = DEF_TICK_MS,
  localparam int IDX_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // tick input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [NUM_BUTTONS-1:0] pin_levels,
  // event output
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_W-1:0]       button_index,
  output logic                   long_press,
  output logic                   last
);

  // Division by TICK_MS as a multiply by a rounded-up reciprocal; with this
  // shift the quotient is exact for every 16-bit dividend.
  localparam int          DIV_SH  = CFG_W + $clog2(TICK_MS);
  localparam int          MULT_W  = CFG_W + 2;
  localparam longint      MULT_LI = ((64'd1 << DIV_SH) + TICK_MS - 1) / TICK_MS;
  localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_LI);
  localparam int          PROD_W  = CFG_W + MULT_W;
  localparam int          NEED_RST_I = (30 / TICK_MS + 1 > 8191) ? 8191 : 30 / TICK_MS + 1;
  localparam logic [COUNT_W-1:0] NEED_RST = COUNT_W'(NEED_RST_I);

  // --- configuration --------------------------------------------------------
  logic [COUNT_W-1:0] need;       // debounce length in ticks
  logic [HELD_W-1:0]  lim;        // long press limit in ms
  logic [CFG_W-1:0]   deb_eff;
  logic [PROD_W-1:0]  prod;
  logic [CFG_W:0]     need_wide;
  logic [COUNT_W-1:0] need_next;

  always_comb begin
    deb_eff   = (cfg_data == '0) ? DEF_DEBOUNCE_MS : cfg_data;
    prod      = PROD_W'(deb_eff) * PROD_W'(MULT);
    need_wide = (CFG_W+1)'(prod >> DIV_SH) + 1'b1;
    need_next = (need_wide > (CFG_W+1)'(COUNT_MAX)) ? COUNT_MAX : need_wide[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need <= NEED_RST;
      lim  <= DEF_LONG_MS;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_MS: need <= need_next;
        REG_LONG_MS:     lim  <= (cfg_data == '0) ? DEF_LONG_MS : cfg_data;
        default:         ;
      endcase
    end
  end

  // --- input register -------------------------------------------------------
  logic                   tick_q;
  logic [NUM_BUTTONS-1:0] levels_q;
  logic                   can_load;
  logic                   adv;      // tick in the register is processed now

  assign adv      = tick_q && can_load;
  assign in_ready = !tick_q || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q <= 1'b0;
    end else if (in_ready) begin
      tick_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) levels_q <= pin_levels;
  end

  // --- button lanes ---------------------------------------------------------
  logic [NUM_BUTTONS-1:0] hit_v, long_v;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    lane_evt_t evt;
    bdlp_lane #(.TICK_MS(TICK_MS)) u_lane (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .level (levels_q[b]),
      .need  (need),
      .lim   (lim),
      .evt   (evt)
    );
    assign hit_v[b]  = evt.hit;
    assign long_v[b] = evt.is_long;
  end

  // --- event register -------------------------------------------------------
  bdlp_evq #(.NUM_BUTTONS(NUM_BUTTONS), .IDX_W(IDX_W)) u_evq (
    .clk          (clk),
    .rst          (rst),
    .load         (adv),
    .load_hit     (hit_v),
    .load_long    (long_v),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_index (button_index),
    .long_press   (long_press),
    .last         (last)
  );

  // --- assertions -----------------------------------------------------------
  // an event that is not the last of its tick leaves more behind it
  a_more_after_nonlast: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("events of a tick lost after a non-final transaction");

  // once the last event is taken, output goes quiet unless a tick was loaded
  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last && !adv |=> !out_valid)
    else $error("event output invented after final transaction");

  // stalling the input only happens with a tick waiting for the event register
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> tick_q && out_valid)
    else $error("input stalled without a pending tick");

endmodule

// File: hw/rtl/bdlp_lane.sv
// One button: debounce counter, held-time counter and press classification.
module bdlp_lane import bdlp_pkg::*; #(
  parameter int TICK_MS = DEF_TICK_MS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               level,
  input  logic [COUNT_W-1:0] need,
  input  logic [HELD_W-1:0]  lim,
  output lane_evt_t          evt
);

  logic               pressed, pressed_next;
  logic [COUNT_W-1:0] cnt, cnt_next;
  logic [HELD_W-1:0]  held, held_next;
  logic               sent, sent_next;

  logic               raw;
  logic [HELD_W:0]    held_sum;
  logic [COUNT_W-1:0] cnt_inc;

  always_comb begin
    raw          = ~level;
    pressed_next = pressed;
    sent_next    = sent;
    cnt_next     = cnt;
    held_next    = held;
    evt          = '0;

    // held time runs only while pressed and no long event yet
    held_sum = {1'b0, held} + (HELD_W+1)'(TICK_MS);
    if (pressed && !sent) begin
      held_next = held_sum[HELD_W] ? HELD_MAX : held_sum[HELD_W-1:0];
    end

    cnt_inc = (cnt < COUNT_MAX) ? cnt + 1'b1 : cnt;
    if (raw == pressed) begin
      cnt_next = '0;
    end else if (cnt_inc >= need) begin
      cnt_next     = '0;
      pressed_next = raw;
      if (raw) begin
        held_next = '0;
        sent_next = 1'b0;
      end else if (!sent) begin
        evt.hit = 1'b1;
      end
    end else begin
      cnt_next = cnt_inc;
    end

    if (pressed_next && !sent_next && held_next >= lim) begin
      sent_next   = 1'b1;
      evt.hit     = 1'b1;
      evt.is_long = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed <= 1'b0;
      cnt     <= '0;
      held    <= '0;
      sent    <= 1'b0;
    end else if (en) begin
      pressed <= pressed_next;
      cnt     <= cnt_next;
      held    <= held_next;
      sent    <= sent_next;
    end
  end

endmodule

// File: hw/rtl/bdlp_evq.sv
// Event register: holds one tick's events and sends them out in button order.
module bdlp_evq import bdlp_pkg::*; #(
  parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
  parameter int IDX_W       = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [NUM_BUTTONS-1:0] load_hit,
  input  logic [NUM_BUTTONS-1:0] load_long,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_W-1:0]       button_index,
  output logic                   long_press,
  output logic                   last
);

  logic [NUM_BUTTONS-1:0] pend, pend_next;
  logic [NUM_BUTTONS-1:0] longm;
  logic [NUM_BUTTONS-1:0] low;
  logic                   fire;

  always_comb begin
    low          = pend & (~pend + 1'b1);
    button_index = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (pend[i]) button_index = IDX_W'(i);
    end
    out_valid  = |pend;
    long_press = |(low & longm);
    last       = ((pend & ~low) == '0);
    fire       = out_valid && out_ready;
    can_load   = !out_valid || (fire && last);
    pend_next  = pend;
    if (load) begin
      pend_next = load_hit;
    end else if (fire) begin
      pend_next = pend & ~low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) longm <= load_long;
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the button debounce / long press block.
module testbench;
  import bdlp_pkg::*;

  // Block geometry and run limits.
  localparam int NUM_BTN         = DEF_NUM_BUTTONS;
  localparam int TICK            = DEF_TICK_MS;
  localparam int IDX_W           = (NUM_BTN > 1) ? $clog2(NUM_BTN) : 1;
  // Input register, lane update and event register, plus margin.
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_PHASES   = 4;
  localparam int TICKS_PER_PHASE = 160;

  // One expected press event, as it leaves the block.
  typedef struct packed {
    logic [IDX_W-1:0] button;
    logic             is_long;
    logic             last;
  } press_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_DEBOUNCE_MS;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [NUM_BTN-1:0]   pin_levels = '1;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [IDX_W-1:0]     button_index;
  logic                 long_press;
  logic                 last;

  button_debounce_long_press_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_levels   (pin_levels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_index (button_index),
    .long_press   (long_press),
    .last         (last)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Press predictor: own copy of the configuration and per-button state.
  // Updated on every accepted tick transaction and every register write.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   debounce_cfg = DEF_DEBOUNCE_MS;
  logic [CFG_W-1:0]   long_cfg     = DEF_LONG_MS;
  logic               pressed_q     [NUM_BTN] = '{default: 1'b0};
  logic [COUNT_W-1:0] stable_q      [NUM_BTN] = '{default: '0};
  logic [HELD_W-1:0]  held_q        [NUM_BTN] = '{default: '0};
  logic               long_sent_q   [NUM_BTN] = '{default: 1'b0};

  press_event_t pending_events[$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           burst_left  = 0;

  // Works out the events one tick causes and queues them in button order.
  task automatic predict_press_events(input logic [NUM_BTN-1:0] levels);
    press_event_t tick_events[$];
    press_event_t ev;
    int unsigned  need, lim, held_sum, deb;
    logic         raw, hit, is_long;
    deb  = (debounce_cfg == '0) ? DEF_DEBOUNCE_MS : debounce_cfg;
    need = deb / TICK + 1;
    if (need > COUNT_MAX) need = COUNT_MAX;
    lim  = (long_cfg == '0) ? DEF_LONG_MS : long_cfg;
    for (int b = 0; b < NUM_BTN; b++) begin
      raw     = ~levels[b];        // active low pins
      hit     = 1'b0;
      is_long = 1'b0;
      // held time moves on first, so the tick that accepts a press can't fire
      if (pressed_q[b] && !long_sent_q[b]) begin
        held_sum  = held_q[b] + TICK;
        held_q[b] = (held_sum > HELD_MAX) ? HELD_MAX : HELD_W'(held_sum);
      end
      if (raw == pressed_q[b]) begin
        stable_q[b] = '0;
      end else begin
        if (stable_q[b] < COUNT_MAX) stable_q[b] = stable_q[b] + 1'b1;
        if (stable_q[b] >= need) begin
          stable_q[b]  = '0;
          pressed_q[b] = raw;
          if (raw) begin
            held_q[b]      = '0;
            long_sent_q[b] = 1'b0;
          end else if (!long_sent_q[b]) begin
            hit = 1'b1;          // short press on release
          end
        end
      end
      if (pressed_q[b] && !long_sent_q[b] && held_q[b] >= lim) begin
        long_sent_q[b] = 1'b1;
        hit            = 1'b1;
        is_long        = 1'b1;
      end
      if (hit) begin
        ev.button  = IDX_W'(b);
        ev.is_long = is_long;
        ev.last    = 1'b0;
        tick_events.push_back(ev);
      end
    end
    if (tick_events.size() > 0) tick_events[tick_events.size()-1].last = 1'b1;
    foreach (tick_events[k]) pending_events.push_back(tick_events[k]);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. Valid stays up
  // between back-to-back transactions; only the payload moves.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [NUM_BTN-1:0] levels);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    pin_levels <= levels;
    do @(posedge clk); while (!in_ready);
    predict_press_events(levels);
    burst_left--;
  endtask

  task automatic hold_levels(input logic [NUM_BTN-1:0] levels, input int ticks);
    repeat (ticks) send_tick(levels);
  endtask

  // Drops valid and lets every expected event arrive, then lets the pipeline
  // settle, since a tick with no event leaves nothing to wait on.
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE_MS: debounce_cfg = value;
      REG_LONG_MS:     long_cfg     = value;
      default:         ;
    endcase
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold);
    wait_idle();
    write_reg(REG_DEBOUNCE_MS, deb);
    write_reg(REG_LONG_MS, hold);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern picks a random mode whenever the low seven bits of
  // the cycle counter wrap - always ready, three in four, coin toss, or one in eight.
  // ---------------------------------------------------------------------------
  logic [31:0] rx_cycle = '0;
  logic [1:0]  rx_mode  = '0;

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[6:0] == '0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= (rx_cycle[1:0] != 2'd0);
      2'd2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (rx_cycle[2:0] == 3'd0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Event checker: every output transaction against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [3:0] want,
                             input logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    press_event_t want_ev;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual button %0d long %0d last %0d",
                 $time, button_index, long_press, last);
        error_count++;
      end else begin
        want_ev = pending_events.pop_front();
        check_field("button_index", 4'(want_ev.button), 4'(button_index));
        check_field("long_press", 4'(want_ev.is_long), 4'(long_press));
        check_field("last", 4'(want_ev.last), 4'(last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d events still expected", $time, pending_events.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: 30 ms debounce means four ticks. Glitches, single short
  // presses and both buttons released on the same tick.
  task automatic test_reset_defaults();
    hold_levels(2'b11, 3);
    hold_levels(2'b10, 3);   // one tick short of debouncing
    hold_levels(2'b11, 2);
    hold_levels(2'b10, 4);
    hold_levels(2'b11, 4);   // short on button 0
    hold_levels(2'b01, 5);
    hold_levels(2'b11, 5);   // short on button 1
    hold_levels(2'b00, 5);
    hold_levels(2'b11, 5);   // two shorts in one tick
  endtask

  // Zero in both registers falls back to 30 ms and 3000 ms. Both buttons
  // reach the long limit on the same tick; release then gives no short.
  task automatic test_zero_registers();
    set_config('0, '0);
    hold_levels(2'b00, 4 + 300 + 2);
    hold_levels(2'b11, 6);
  endtask

  // Smallest settings: one-tick debounce and a limit hit on the first tick
  // after the press, never on the press tick itself.
  task automatic test_fast_settings();
    set_config(16'd1, 16'd1);
    send_tick(2'b10);        // press, no event
    send_tick(2'b10);        // long on button 0
    send_tick(2'b11);        // release after long: silent
    send_tick(2'b00);
    send_tick(2'b11);        // both short together
    send_tick(2'b00);
    send_tick(2'b10);        // long on 0 and short on 1 in the same tick
    send_tick(2'b11);
    set_config(16'd9, 16'd10);
    hold_levels(2'b01, 2);
    hold_levels(2'b11, 2);
    set_config(16'd10, 16'd20);
    hold_levels(2'b00, 4);
    hold_levels(2'b11, 3);
  endtask

  // Large settings: the widest debounce register (6554 ticks) keeps two
  // pressed buttons from settling, then a 50-tick debounce with a 500 ms
  // limit gives a long press followed by a silent release.
  task automatic test_extreme_settings();
    set_config(16'hFFFF, 16'hFFFF);
    hold_levels(2'b00, 100);     // far short of debouncing
    hold_levels(2'b11, 4);
    set_config(16'd499, 16'd500);
    hold_levels(2'b10, 105);     // press at tick 50, long at tick 100
    hold_levels(2'b11, 55);
  endtask

  // Random phases: each button follows its own press/release script with
  // glitches, short and long holds, plus occasional one-tick bounces.
  task automatic test_random_traffic();
    logic [NUM_BTN-1:0] target, levels;
    logic [CFG_W-1:0]   deb, hold;
    int                 run_left [NUM_BTN];
    int                 need, long_ticks, pick, flip;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0:       deb = '0;
        1:       deb = CFG_W'($urandom_range(1, 9));
        default: deb = CFG_W'($urandom_range(10, 60));
      endcase
      case ($urandom_range(0, 7))
        0:       hold = '0;
        1:       hold = CFG_W'($urandom_range(1, 30));
        default: hold = CFG_W'($urandom_range(31, 400));
      endcase
      set_config(deb, hold);
      need       = ((deb == '0) ? 30 : deb) / TICK + 1;
      long_ticks = ((hold == '0) ? 3000 : hold) / TICK + 1;
      target     = '1;
      foreach (run_left[b]) run_left[b] = 0;
      repeat (TICKS_PER_PHASE) begin
        for (int b = 0; b < NUM_BTN; b++) begin
          if (run_left[b] == 0) begin
            target[b] = ~target[b];
            pick      = $urandom_range(0, 9);
            if (pick < 2)
              run_left[b] = $urandom_range(1, (need > 1) ? need - 1 : 1);
            else if (target[b] || pick < 6)
              run_left[b] = need + $urandom_range(0, 10);
            else
              run_left[b] = need + long_ticks + $urandom_range(0, 8);
          end
          run_left[b]--;
        end
        levels = target;
        if ($urandom_range(0, 15) == 0) begin
          flip         = $urandom_range(0, NUM_BTN - 1);
          levels[flip] = ~levels[flip];
        end
        send_tick(levels);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_defaults();
    test_zero_registers();
    test_fast_settings();
    test_extreme_settings();
    test_random_traffic();

    wait_idle();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bdlp_pkg.sv
hw/rtl/bdlp_lane.sv
hw/rtl/bdlp_evq.sv
hw/rtl/button_debounce_long_press_top.sv
verif/testbench.sv
